@@ design/tam_pkg.sv @@
// Shared constants, types and helpers for the tile average character mapper.
// No dependencies; every other design file but tam_column_ram uses this package.
package tam_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_WIDTH = 2048;
  localparam int DEF_MAX_TILE  = 64;
  localparam int DEF_LEVELS    = 11;

  // Fixed field and state widths
  localparam int COMP_W     = 8;
  localparam int PIX_SUM_W  = 10;
  localparam int SUM_W      = 22;
  localparam int POS_W      = 11;
  localparam int CHAR_W     = 7;
  localparam int LVL_OUT_W  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 12;
  localparam int TILE_W     = 7;

  localparam int HEIGHT_LIMIT = 2048;
  localparam int TILE_LIMIT   = 127;  // largest value a tile_edge write can hold
  localparam int SCALE_DIV    = 255;
  localparam int RAMP_LEN     = 11;

  // x/255 as (x*SCALE_RECIP) >> SCALE_SHIFT; exact for x below 21959,
  // which covers 255*64
  localparam int SCALE_RECIP  = 16449;
  localparam int SCALE_SHIFT  = 22;

  localparam logic [WIDTH_W-1:0]  RST_FRAME_WIDTH  = 12'd1280;
  localparam logic [HEIGHT_W-1:0] RST_FRAME_HEIGHT = 12'd720;
  localparam logic [TILE_W-1:0]   RST_TILE_EDGE    = 7'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_TILE_EDGE    = 2'd2
  } tam_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } tam_div_stat_t;

  // Zero reads as one, anything above the limit as the limit.
  function automatic logic [CFG_DATA_W-1:0] clamp_reg(input logic [CFG_DATA_W-1:0] v,
                                                      input int unsigned hi);
    logic [CFG_DATA_W-1:0] r;
    if (v == '0) begin
      r = CFG_DATA_W'(1);
    end else if (32'(v) > hi) begin
      r = CFG_DATA_W'(hi);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Brightness ramp " .,:-=+*#%@"
  function automatic logic [CHAR_W-1:0] ramp_char(input logic [3:0] i);
    logic [CHAR_W-1:0] c;
    case (i)
      4'd0:    c = 7'd32;
      4'd1:    c = 7'd46;
      4'd2:    c = 7'd44;
      4'd3:    c = 7'd58;
      4'd4:    c = 7'd45;
      4'd5:    c = 7'd61;
      4'd6:    c = 7'd43;
      4'd7:    c = 7'd42;
      4'd8:    c = 7'd35;
      4'd9:    c = 7'd37;
      default: c = 7'd64;
    endcase
    return c;
  endfunction

endpackage

@@ design/tam_pix_if.sv @@
// Pixel channel: valid/ready handshake carrying one RGB pixel.
// Depends on tam_pkg for component widths.
interface tam_pix_if;
  logic                       valid;
  logic                       ready;
  logic [tam_pkg::COMP_W-1:0] red;
  logic [tam_pkg::COMP_W-1:0] green;
  logic [tam_pkg::COMP_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

@@ design/tam_char_if.sv @@
// Character channel: valid/ready handshake carrying one mapped tile.
// Depends on tam_pkg for field widths.
interface tam_char_if;
  logic                          valid;
  logic                          ready;
  logic [tam_pkg::CHAR_W-1:0]    char_code;
  logic [tam_pkg::LVL_OUT_W-1:0] level_index;
  logic                          row_end;
  logic                          frame_end;

  modport source (output valid, output char_code, output level_index, output row_end,
                  output frame_end, input ready);
  modport sink   (input valid, input char_code, input level_index, input row_end,
                  input frame_end, output ready);
endinterface

@@ design/tam_column_ram.sv @@
// Column accumulator store: one write port, one read port, registered read data.
// Read-before-write on a shared address; the caller forwards.
module tam_column_ram #(
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = 11,
  parameter int DATA_W = 22
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);
  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ design/tam_divider.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on tam_pkg for the status struct.
module tam_divider #(
  parameter int DIVD_W = 26,
  parameter int DIVR_W = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [DIVD_W-1:0]      dividend,
  input  logic [DIVR_W-1:0]      divisor,
  output tam_pkg::tam_div_stat_t stat,
  output logic [DIVD_W-1:0]      quotient
);
  import tam_pkg::*;

  localparam int CNT_W = (DIVD_W > 1) ? $clog2(DIVD_W) : 1;

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [DIVD_W-1:0] q;
  logic [DIVR_W-1:0] rem;
  logic [DIVR_W-1:0] dvs;
  logic [DIVR_W:0]   trial;
  logic              ge;
  logic [DIVR_W-1:0] rem_next;

  always_comb begin
    trial    = {rem, q[DIVD_W-1]};
    ge       = trial >= {1'b0, dvs};
    rem_next = ge ? DIVR_W'(trial - {1'b0, dvs}) : DIVR_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient bits shift in from the bottom as dividend bits leave the top
  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      q   <= {q[DIVD_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = q;
endmodule

@@ design/tile_average_ascii_mapper.sv @@
// Top level: raster position tracking, column accumulator read-modify-write,
// and the tile average to character sequencer. Uses tam_pkg, both channel
// interfaces, tam_column_ram and tam_divider.
//
//  channel   dir  handshake          payload
//  -------   ---  -----------------  -------------------------------------------
//  pixels    in   valid/ready        red, green, blue (8 bit each)
//  chars     out  valid/ready        char_code(7), level_index(4), row_end, frame_end
//  cfg       in   cfg_write strobe   cfg_index(2), cfg_data(12); no read-back
//
// After reset the column store is cleared one entry a cycle; pixels.ready
// stays low during that pass, config writes are taken.
// Pixels that do not finish a tile transfer back to back, same-column
// accesses being forwarded around the RAM.
// A pixel that finishes a tile holds pixels.ready low while the tile is mapped:
// a start step, the one-bit-per-cycle divider for sum/(3*t*t), then one step
// each to take the quotient, scale it by LEVELS/255 with a reciprocal
// multiply, and load the output register.
// The result sits in an output register; a stalled chars channel blocks only
// the next tile-finishing pixel, not the pixels in between.
module tile_average_ascii_mapper #(
  parameter int MAX_WIDTH = tam_pkg::DEF_MAX_WIDTH,
  parameter int MAX_TILE  = tam_pkg::DEF_MAX_TILE,
  parameter int LEVELS    = tam_pkg::DEF_LEVELS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [tam_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tam_pkg::CFG_DATA_W-1:0] cfg_data,
  tam_pix_if.sink                        pixels,
  tam_char_if.source                     chars
);
  import tam_pkg::*;

  localparam int ADDR_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int TCNT_W  = (MAX_TILE > 1) ? $clog2(MAX_TILE) : 1;
  localparam int TMAX    = (MAX_TILE < TILE_LIMIT) ? MAX_TILE : TILE_LIMIT;
  localparam int AREA_W  = $clog2(3 * TMAX * TMAX + 1);
  localparam int SCALE_W = $clog2(SCALE_DIV + 1);
  localparam int DIVR_W  = AREA_W;
  localparam int LVL_W   = $clog2(LEVELS);
  localparam int DIVD_W  = SUM_W;
  localparam int PROD_W  = SCALE_W + $clog2(LEVELS + 1);
  localparam int RECIP_W = $clog2(SCALE_RECIP + 1);
  localparam int MUL_W   = PROD_W + RECIP_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_RUN,
    ST_AVG,
    ST_SCALE,
    ST_EMIT
  } state_t;

  // Configuration registers
  logic [WIDTH_W-1:0]  frame_width;
  logic [HEIGHT_W-1:0] frame_height;
  logic [TILE_W-1:0]   tile_edge;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
      tile_edge    <= RST_TILE_EDGE;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data[WIDTH_W-1:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_data[HEIGHT_W-1:0];
        CFG_TILE_EDGE:    tile_edge    <= cfg_data[TILE_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective limits: zero counts as one, oversize as the maximum
  logic [WIDTH_W-1:0]  w_lim;
  logic [HEIGHT_W-1:0] h_lim;
  logic [TILE_W-1:0]   t_lim;
  logic [2*TILE_W-1:0] t_sq;
  logic [AREA_W-1:0]   area;

  assign w_lim = clamp_reg(frame_width, MAX_WIDTH);
  assign h_lim = clamp_reg(frame_height, HEIGHT_LIMIT);
  assign t_lim = TILE_W'(clamp_reg(CFG_DATA_W'(tile_edge), MAX_TILE));
  assign t_sq  = (2*TILE_W)'(t_lim) * (2*TILE_W)'(t_lim);

  // Divisor for the full tile area, 3*t*t; times three is shift and add
  always_ff @(posedge clk) begin
    area <= AREA_W'({t_sq, 1'b0} + {1'b0, t_sq});
  end

  // Raster position
  logic [POS_W-1:0]  pix_col, pix_col_next;
  logic [POS_W-1:0]  pix_row, pix_row_next;
  logic [POS_W-1:0]  tile_col, tile_col_next;
  logic [TCNT_W-1:0] col_in_tile, col_in_tile_next;
  logic [TCNT_W-1:0] row_in_tile, row_in_tile_next;
  logic              last_col, last_row, tcol_end, trow_end, tile_done;
  logic [31:0]       idx_full;
  logic [ADDR_W-1:0] rd_addr;
  logic              accept;

  state_t state;

  logic               s1_valid;
  logic               s1_done;
  logic               s1_row_end;
  logic               s1_frame_end;
  logic [PIX_SUM_W-1:0] s1_pix;
  logic [ADDR_W-1:0]  s1_idx;
  logic               fwd;
  logic [SUM_W-1:0]   fwd_data;
  logic [SUM_W-1:0]   s1_sum;
  logic [SUM_W-1:0]   s1_wdata;

  assign pixels.ready = (state == ST_RUN) && !(s1_valid && s1_done);
  assign accept       = pixels.valid && pixels.ready;

  always_comb begin
    last_col  = 32'(pix_col) >= 32'(w_lim) - 32'd1;
    last_row  = 32'(pix_row) >= 32'(h_lim) - 32'd1;
    tcol_end  = last_col || (32'(col_in_tile) >= 32'(t_lim) - 32'd1);
    trow_end  = last_row || (32'(row_in_tile) >= 32'(t_lim) - 32'd1);
    tile_done = tcol_end && trow_end;
    idx_full  = (32'(tile_col) < MAX_WIDTH) ? 32'(tile_col) : 32'(MAX_WIDTH - 1);
    rd_addr   = ADDR_W'(idx_full);

    pix_col_next     = pix_col;
    pix_row_next     = pix_row;
    tile_col_next    = tile_col;
    col_in_tile_next = col_in_tile;
    row_in_tile_next = row_in_tile;
    if (last_col) begin
      pix_col_next     = '0;
      col_in_tile_next = '0;
      tile_col_next    = '0;
      if (last_row) begin
        pix_row_next     = '0;
        row_in_tile_next = '0;
      end else begin
        pix_row_next     = pix_row + 1'b1;
        row_in_tile_next = trow_end ? '0 : row_in_tile + 1'b1;
      end
    end else begin
      pix_col_next = pix_col + 1'b1;
      if (tcol_end) begin
        col_in_tile_next = '0;
        tile_col_next    = tile_col + 1'b1;
      end else begin
        col_in_tile_next = col_in_tile + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_col     <= '0;
      pix_row     <= '0;
      tile_col    <= '0;
      col_in_tile <= '0;
      row_in_tile <= '0;
    end else if (accept) begin
      pix_col     <= pix_col_next;
      pix_row     <= pix_row_next;
      tile_col    <= tile_col_next;
      col_in_tile <= col_in_tile_next;
      row_in_tile <= row_in_tile_next;
    end
  end

  // Accumulator RAM: read on transfer, write back in the following cycle
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [SUM_W-1:0]  mem_wdata;
  logic [SUM_W-1:0]  mem_rdata;
  logic [ADDR_W-1:0] clr_addr;

  tam_column_ram #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (ADDR_W),
    .DATA_W (SUM_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (mem_rdata)
  );

  // Second stage: add the pixel, clear the column when its tile completes.
  // The previous pixel's write lands on the same edge as this read, so a
  // matching column takes the written value instead of the RAM output.
  always_comb begin
    s1_sum   = (fwd ? fwd_data : mem_rdata) + SUM_W'(s1_pix);
    s1_wdata = s1_done ? '0 : s1_sum;
  end

  always_comb begin
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = s1_valid;
      mem_waddr = s1_idx;
      mem_wdata = s1_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix       <= PIX_SUM_W'(pixels.red) + PIX_SUM_W'(pixels.green)
                      + PIX_SUM_W'(pixels.blue);
      s1_idx       <= rd_addr;
      s1_done      <= tile_done;
      s1_row_end   <= last_col;
      s1_frame_end <= last_col && last_row;
      fwd          <= s1_valid && (s1_idx == rd_addr);
      fwd_data     <= s1_wdata;
    end
  end

  // Divider for the tile average, sum/(3*t*t)
  logic                  div_start;
  logic [DIVD_W-1:0]     div_dividend;
  logic [DIVR_W-1:0]     div_divisor;
  tam_div_stat_t         div_stat;
  logic [DIVD_W-1:0]     div_quot;

  assign div_start    = (state == ST_RUN) && s1_valid && s1_done;
  assign div_dividend = s1_sum;
  assign div_divisor  = area;

  tam_divider #(
    .DIVD_W (DIVD_W),
    .DIVR_W (DIVR_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  // Sequencer and output register
  logic [PROD_W-1:0]    prod;
  logic [SCALE_W-1:0]   avg_sat;
  logic [MUL_W-1:0]     scaled;
  logic [MUL_W-1:0]     lvl_raw;
  logic [LVL_W-1:0]     level;
  logic                 tile_row_end;
  logic                 tile_frame_end;
  logic                 out_valid;
  logic [CHAR_W-1:0]    out_char;
  logic [LVL_OUT_W-1:0] out_level;
  logic                 out_row_end;
  logic                 out_frame_end;
  logic [31:0]          ramp_idx;

  // Any average at or above full scale lands on the last level after clamping,
  // so saturating it first keeps the scaling product narrow.
  assign avg_sat = (div_quot > DIVD_W'(SCALE_DIV)) ? SCALE_W'(SCALE_DIV)
                                                   : SCALE_W'(div_quot);
  // Division by 255 as a multiply by the rounded-up reciprocal
  assign scaled  = MUL_W'(prod) * MUL_W'(SCALE_RECIP);
  assign lvl_raw = scaled >> SCALE_SHIFT;

  assign ramp_idx = (32'(level) < RAMP_LEN) ? 32'(level) : 32'(RAMP_LEN - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && chars.ready && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(MAX_WIDTH - 1)) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (s1_valid && s1_done) begin
            tile_row_end   <= s1_row_end;
            tile_frame_end <= s1_frame_end;
            state          <= ST_AVG;
          end
        end
        ST_AVG: begin
          if (div_stat.done) begin
            prod  <= PROD_W'(avg_sat) * PROD_W'(LEVELS);
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          // a full-brightness tile lands one past the last level
          level <= (lvl_raw > MUL_W'(LEVELS - 1)) ? LVL_W'(LEVELS - 1)
                                                  : LVL_W'(lvl_raw);
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid || chars.ready) begin
            out_valid     <= 1'b1;
            out_char      <= ramp_char(4'(ramp_idx));
            out_level     <= LVL_OUT_W'(level);
            out_row_end   <= tile_row_end;
            out_frame_end <= tile_frame_end;
            state         <= ST_RUN;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

  assign chars.valid       = out_valid;
  assign chars.char_code   = out_char;
  assign chars.level_index = out_level;
  assign chars.row_end     = out_row_end;
  assign chars.frame_end   = out_frame_end;

  // Checks
  a_no_pixels_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !pixels.ready)
    else $error("pixel ready during clearing pass");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_tile_end_starts_div: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_done) |-> div_start)
    else $error("completed tile did not start the divider");

  a_no_pixels_while_dividing: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> !pixels.ready)
    else $error("pixel taken while a tile is being mapped");

  a_level_clamped: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (32'(level) <= LEVELS - 1))
    else $error("level beyond the last ramp entry");
endmodule
